>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the rasterizer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph cell rasterizer package
// Shared constants, the character descriptor type and the 5x7 glyph table.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd128;
  localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd160;
  localparam logic [10:0] MAX_SCREEN          = 11'd1024;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd127;
  localparam logic [7:0] CHAR_SUBST = 8'h3F;

  localparam logic [2:0] LAST_COL = 3'd4;
  localparam logic [2:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic [39:0] glyph;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] fg_color;
    logic [15:0] back_color;
    logic [7:0]  scale;
  } gcr_desc_t;

  // Column c of a glyph occupies bits [8c+7:8c]; bit r of a column is row r.
  localparam logic [39:0] GLYPH_ROM [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
    40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h081C2A0808, 40'h08082A1C08
  };

  function automatic logic [39:0] glyph_lookup(input logic [7:0] code);
    logic [7:0] c;
    logic [6:0] idx;
    c = ((code < CHAR_FIRST) || (code > CHAR_LAST)) ? CHAR_SUBST : code;
    idx = 7'(c - CHAR_FIRST);
    return GLYPH_ROM[idx];
  endfunction

endpackage

>>> rtl/gcr_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Carries one character word: code, cell origin, colours and scale.
// ----------------------------------------------------------------------------
interface gcr_char_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] fg_color;
  logic [15:0] back_color;
  logic [7:0]  scale;

  modport source (output valid, char_code, origin_x, origin_y, fg_color, back_color, scale,
                  input ready);
  modport sink (input valid, char_code, origin_x, origin_y, fg_color, back_color, scale,
                output ready);
endinterface

>>> rtl/gcr_rect_if.sv
// ----------------------------------------------------------------------------
// Rectangle channel
// Carries one clipped fill rectangle word with its colour and end marker.
// ----------------------------------------------------------------------------
interface gcr_rect_if;
  logic        valid;
  logic        ready;
  logic [9:0]  rect_x;
  logic [9:0]  rect_y;
  logic [7:0]  rect_w;
  logic [10:0] rect_h;
  logic [15:0] rect_color;
  logic        last;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_color, last,
                  input ready);
  modport sink (input valid, rect_x, rect_y, rect_w, rect_h, rect_color, last,
                output ready);
endinterface

>>> rtl/gcr_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one register write word: register index and data.
// ----------------------------------------------------------------------------
interface gcr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [gcr_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [10:0]                          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/glyph_cell_rect_rasterizer.sv
// ----------------------------------------------------------------------------
// Glyph cell rectangle rasterizer
// Turns 5x7 characters into clipped fill rectangles for a pixel panel.
// ----------------------------------------------------------------------------
// The cell walker feeds the candidate stage, pending rectangle and output
// register. Throughput: one cell per cycle in the generator unless the output
// stalls, so a character covers 40 cells, or 41 with the background spacer
// column; a zero-scale character is dropped in the front end. Reset sets the
// screen to 128 by 160 and empties the queue and the output pipeline.
module glyph_cell_rect_rasterizer #(
  parameter int COORD_WIDTH = gcr_pkg::COORD_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = gcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  gcr_char_if.sink   chars,
  gcr_rect_if.source rects,
  gcr_cfg_if.sink    cfg
);

  logic [10:0]         screen_width;
  logic [10:0]         screen_height;
  logic [10:0]         cfg_clamped;
  logic                q_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  gcr_pkg::gcr_desc_t  q_din;
  gcr_pkg::gcr_desc_t  q_dout;

  assign cfg.ready   = 1'b1;
  assign cfg_clamped = (cfg.data > gcr_pkg::MAX_SCREEN) ? gcr_pkg::MAX_SCREEN : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= gcr_pkg::SCREEN_WIDTH_RESET;
      screen_height <= gcr_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        gcr_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_clamped;
        gcr_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_clamped;
        default: ;
      endcase
    end
  end

  gcr_front u_front (
    .chars (chars),
    .full  (q_full),
    .push  (q_push),
    .desc  (q_din)
  );

  gcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_dout)
  );

  gcr_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (q_valid),
    .desc          (q_dout),
    .desc_pop      (q_pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .rects         (rects)
  );

endmodule

>>> rtl/gcr_front.sv
// ----------------------------------------------------------------------------
// Rasterizer front end
// Accepts character words, drops zero-scale ones and looks up the glyph.
// ----------------------------------------------------------------------------
module gcr_front (
  gcr_char_if.sink             chars,
  input  logic                 full,
  output logic                 push,
  output gcr_pkg::gcr_desc_t   desc
);

  assign chars.ready = !full;
  assign push        = chars.valid && !full && (chars.scale != 8'd0);

  always_comb begin
    desc.glyph      = gcr_pkg::glyph_lookup(chars.char_code);
    desc.origin_x   = chars.origin_x;
    desc.origin_y   = chars.origin_y;
    desc.fg_color   = chars.fg_color;
    desc.back_color = chars.back_color;
    desc.scale      = chars.scale;
  end

endmodule

>>> rtl/gcr_queue.sv
// ----------------------------------------------------------------------------
// Descriptor queue
// Short FIFO between the front end and the rectangle generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcr_queue #(
  parameter int DEPTH = gcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gcr_pkg::gcr_desc_t  din,
  output logic                full,
  output logic                valid,
  input  logic                pop,
  output gcr_pkg::gcr_desc_t  dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gcr_pkg::gcr_desc_t  mem [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full || pop)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, valid)

endmodule

>>> rtl/gcr_back.sv
// ----------------------------------------------------------------------------
// Rasterizer back end
// Walks the glyph cells, clips each rectangle and marks the final word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcr_back #(
  parameter int COORD_WIDTH = gcr_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_valid,
  input  gcr_pkg::gcr_desc_t  desc,
  output logic                desc_pop,
  input  logic [10:0]         screen_width,
  input  logic [10:0]         screen_height,
  gcr_rect_if.source          rects
);

  localparam int CW   = COORD_WIDTH;
  localparam int CMPW = ((CW > 11) ? CW : 11) + 1;

  // Cell walker
  logic           busy;
  logic [2:0]     col;
  logic [2:0]     row;
  logic           spacer;
  logic [CW-1:0]  x_acc;
  logic [CW-1:0]  y_acc;
  logic [CW-1:0]  oy_r;
  logic [39:0]    glyph_r;
  logic [15:0]    fg_r;
  logic [15:0]    bg_r;
  logic [7:0]     scale_r;

  // Candidate stage
  logic           c_valid;
  logic           c_emit;
  logic           c_final;
  logic [CW-1:0]  c_x;
  logic [CW-1:0]  c_y;
  logic [7:0]     c_w;
  logic [10:0]    c_h;
  logic [15:0]    c_color;

  // Pending rectangle
  logic           p_valid;
  logic           p_final;
  logic [9:0]     p_x;
  logic [9:0]     p_y;
  logic [7:0]     p_w;
  logic [10:0]    p_h;
  logic [15:0]    p_color;

  // Output register
  logic           o_valid;
  logic           o_last;
  logic [9:0]     o_x;
  logic [9:0]     o_y;
  logic [7:0]     o_w;
  logic [10:0]    o_h;
  logic [15:0]    o_color;

  logic           paint_bg;
  logic           adv;
  logic           gen_fire;
  logic           last_step;
  logic           done;
  logic           cell_bit;

  logic [CMPW-1:0] x_e;
  logic [CMPW-1:0] y_e;
  logic [CMPW-1:0] sw_e;
  logic [CMPW-1:0] sh_e;
  logic [CMPW-1:0] x_end;
  logic [CMPW-1:0] y_end;
  logic            c_vis;
  logic [7:0]      w_clip;
  logic [10:0]     h_clip;
  logic            o_load;
  logic            o_last_val;

  assign paint_bg  = (fg_r != bg_r);
  assign adv       = !o_valid || rects.ready;
  assign gen_fire  = busy && adv;
  assign cell_bit  = glyph_r[{col, row}];
  assign last_step = spacer ||
                     ((col == gcr_pkg::LAST_COL) && (row == gcr_pkg::LAST_ROW) && !paint_bg);
  assign done      = gen_fire && last_step;
  assign desc_pop  = desc_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (desc_pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      col     <= '0;
      row     <= '0;
      spacer  <= 1'b0;
      x_acc   <= desc.origin_x[CW-1:0];
      y_acc   <= desc.origin_y[CW-1:0];
      oy_r    <= desc.origin_y[CW-1:0];
      glyph_r <= desc.glyph;
      fg_r    <= desc.fg_color;
      bg_r    <= desc.back_color;
      scale_r <= desc.scale;
    end else if (gen_fire && !last_step) begin
      if (row == gcr_pkg::LAST_ROW) begin
        if (col == gcr_pkg::LAST_COL) begin
          spacer <= 1'b1;
        end else begin
          col <= col + 3'd1;
          row <= '0;
        end
        x_acc <= x_acc + CW'(scale_r);
        y_acc <= oy_r;
      end else begin
        row   <= row + 3'd1;
        y_acc <= y_acc + CW'(scale_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= gen_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x     <= x_acc;
      c_y     <= y_acc;
      c_w     <= scale_r;
      c_h     <= spacer ? {scale_r, 3'b000} : {3'b000, scale_r};
      c_color <= (spacer || !cell_bit) ? bg_r : fg_r;
      c_emit  <= spacer || cell_bit || paint_bg;
      c_final <= last_step;
    end
  end

  always_comb begin
    x_e    = CMPW'(c_x);
    y_e    = CMPW'(c_y);
    sw_e   = CMPW'(screen_width);
    sh_e   = CMPW'(screen_height);
    x_end  = x_e + CMPW'(c_w);
    y_end  = y_e + CMPW'(c_h);
    c_vis  = c_valid && c_emit && (x_e < sw_e) && (y_e < sh_e);
    w_clip = (x_end > sw_e) ? 8'(sw_e - x_e) : c_w;
    h_clip = (y_end > sh_e) ? 11'(sh_e - y_e) : c_h;
  end

  assign o_load     = adv && p_valid && (p_final || (c_valid && (c_vis || c_final)));
  assign o_last_val = p_final || (c_valid && c_final && !c_vis);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_final <= 1'b0;
    end else if (adv) begin
      if (c_vis) begin
        p_valid <= 1'b1;
        p_final <= c_final;
      end else if (o_load) begin
        p_valid <= 1'b0;
        p_final <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_vis) begin
      p_x     <= 10'(x_e);
      p_y     <= 10'(y_e);
      p_w     <= w_clip;
      p_h     <= h_clip;
      p_color <= c_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (rects.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_x     <= p_x;
      o_y     <= p_y;
      o_w     <= p_w;
      o_h     <= p_h;
      o_color <= p_color;
      o_last  <= o_last_val;
    end
  end

  assign rects.valid      = o_valid;
  assign rects.rect_x     = o_x;
  assign rects.rect_y     = o_y;
  assign rects.rect_w     = o_w;
  assign rects.rect_h     = o_h;
  assign rects.rect_color = o_color;
  assign rects.last       = o_last;

  `ASSERT_IMPLIES(a_spacer_needs_bg, clk, rst, busy && spacer, paint_bg)
  `ASSERT_IMPLIES(a_rect_nonempty, clk, rst, o_valid, (o_w != 8'd0) && (o_h != 11'd0))
  `ASSERT_NEXT(a_final_flush, clk, rst, adv && p_valid && p_final, o_valid && o_last)

endmodule

>>> test/glyph_cell_rect_rasterizer_test.sv
// ----------------------------------------------------------------------------
// Glyph cell rectangle rasterizer testbench
// Sends character words to the rasterizer and checks every rectangle word
// against a predictor that has its own font table and screen registers. A
// directed part covers the character substitution, zero scale, colour
// equality, coordinate wrap, clipping and the screen register extremes. Random
// characters follow under several screen sizes, with both channels idling at
// random, one long receiver hold-off and sender pauses until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module glyph_cell_rect_rasterizer_test;

  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam logic [7:0] SUBST_CODE = 8'h3F;

  typedef struct {
    logic [7:0]  char_code;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] fg_color;
    logic [15:0] back_color;
    logic [7:0]  scale;
  } glyph_req_t;

  typedef struct {
    logic [9:0]  rect_x;
    logic [9:0]  rect_y;
    logic [7:0]  rect_w;
    logic [10:0] rect_h;
    logic [15:0] rect_color;
    logic        last;
  } fill_rect_t;

  // Five column bytes per character from space upwards; bit r is row r.
  localparam logic [7:0] FONT_COLS [480] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
    8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
    8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
    8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
    8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
    8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
    8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00,
    8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,
    8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C,
    8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
    8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
    8'h08,8'h08,8'h2A,8'h1C,8'h08, 8'h08,8'h1C,8'h2A,8'h08,8'h08
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gcr_char_if char_ch ();
  gcr_rect_if rect_ch ();
  gcr_cfg_if  cfg_ch ();

  glyph_cell_rect_rasterizer dut (
    .clk  (clk),
    .rst  (rst),
    .chars(char_ch),
    .rects(rect_ch),
    .cfg  (cfg_ch)
  );

  always #2 clk = ~clk;

  logic [10:0] screen_w = gcr_pkg::SCREEN_WIDTH_RESET;
  logic [10:0] screen_h = gcr_pkg::SCREEN_HEIGHT_RESET;
  fill_rect_t rects_due[$];
  int failures = 0;
  int chars_sent = 0;
  int rects_seen = 0;
  int screens_used = 1;
  bit idle_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  // Clips one rectangle to the screen; returns 1 if it survives.
  function automatic int put_clipped(int x, int y, int w, int h, logic [15:0] color);
    int eff_w;
    int eff_h;
    fill_rect_t r;
    eff_w = (screen_w > gcr_pkg::MAX_SCREEN) ? int'(gcr_pkg::MAX_SCREEN) : int'(screen_w);
    eff_h = (screen_h > gcr_pkg::MAX_SCREEN) ? int'(gcr_pkg::MAX_SCREEN) : int'(screen_h);
    x = x & 16'hFFFF;
    y = y & 16'hFFFF;
    if (x >= eff_w || y >= eff_h) return 0;
    if (x + w > eff_w) w = eff_w - x;
    if (y + h > eff_h) h = eff_h - y;
    r.rect_x = 10'(x);
    r.rect_y = 10'(y);
    r.rect_w = 8'(w);
    r.rect_h = 11'(h);
    r.rect_color = color;
    r.last = 1'b0;
    rects_due.push_back(r);
    return 1;
  endfunction

  function automatic void rasterise_char(glyph_req_t c);
    int code;
    int s;
    int made;
    logic [7:0] bits;
    bit paint_bg;
    fill_rect_t tail;
    made = 0;
    s = int'(c.scale);
    if (s == 0) return;
    code = int'(c.char_code);
    if (code < int'(gcr_pkg::CHAR_FIRST) || code > int'(gcr_pkg::CHAR_LAST))
      code = int'(SUBST_CODE);
    paint_bg = (c.fg_color != c.back_color);
    for (int col = 0; col < 5; col++) begin
      bits = FONT_COLS[(code - 32) * 5 + col];
      for (int row = 0; row < 8; row++) begin
        if (bits[row]) begin
          made += put_clipped(int'(c.origin_x) + col * s, int'(c.origin_y) + row * s,
                              s, s, c.fg_color);
        end else if (paint_bg) begin
          made += put_clipped(int'(c.origin_x) + col * s, int'(c.origin_y) + row * s,
                              s, s, c.back_color);
        end
      end
    end
    if (paint_bg) begin
      made += put_clipped(int'(c.origin_x) + 5 * s, int'(c.origin_y), s, 8 * s, c.back_color);
    end
    if (made > 0) begin
      tail = rects_due[rects_due.size() - 1];
      tail.last = 1'b1;
      rects_due[rects_due.size() - 1] = tail;
    end
  endfunction

  function automatic glyph_req_t make_char(logic [7:0] code, logic [15:0] ox,
                                           logic [15:0] oy, logic [15:0] fg,
                                           logic [15:0] bg, logic [7:0] s);
    glyph_req_t c;
    c.char_code = code;
    c.origin_x = ox;
    c.origin_y = oy;
    c.fg_color = fg;
    c.back_color = bg;
    c.scale = s;
    return c;
  endfunction

  function automatic logic [15:0] random_origin(logic [10:0] extent);
    int pick;
    int eff;
    eff = (extent > gcr_pkg::MAX_SCREEN) ? int'(gcr_pkg::MAX_SCREEN) : int'(extent);
    pick = $urandom_range(0, 19);
    if (pick < 14) return 16'($urandom_range(0, eff + 8));
    if (pick < 17) return 16'(65535 - $urandom_range(0, 48));
    return 16'($urandom);
  endfunction

  function automatic glyph_req_t random_char();
    glyph_req_t c;
    int pick;
    c.char_code = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 127)) : 8'($urandom);
    c.origin_x = random_origin(screen_w);
    c.origin_y = random_origin(screen_h);
    c.fg_color = 16'($urandom);
    pick = $urandom_range(0, 7);
    if (pick < 2) c.back_color = c.fg_color;
    else if (pick == 2) c.back_color = ~c.fg_color;
    else c.back_color = 16'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) c.scale = 8'd0;
    else if (pick < 3) c.scale = 8'($urandom);
    else if (pick < 7) c.scale = 8'($urandom_range(4, 32));
    else c.scale = 8'($urandom_range(1, 3));
    return c;
  endfunction

  task automatic send_char(glyph_req_t c);
    char_ch.valid <= 1'b1;
    char_ch.char_code <= c.char_code;
    char_ch.origin_x <= c.origin_x;
    char_ch.origin_y <= c.origin_y;
    char_ch.fg_color <= c.fg_color;
    char_ch.back_color <= c.back_color;
    char_ch.scale <= c.scale;
    do @(posedge clk); while (!char_ch.ready);
    rasterise_char(c);
    chars_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    while (rects_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(logic [10:0] w, logic [10:0] h);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= gcr_pkg::CFG_SCREEN_WIDTH;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    screen_w = w;
    cfg_ch.index <= gcr_pkg::CFG_SCREEN_HEIGHT;
    cfg_ch.data <= h;
    do @(posedge clk); while (!cfg_ch.ready);
    screen_h = h;
    cfg_ch.valid <= 1'b0;
    screens_used++;
  endtask

  task automatic test_directed_chars();
    send_char(make_char("A", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd1));
    send_char(make_char("A", 16'd0, 16'd0, 16'h1234, 16'h1234, 8'd2));
    send_char(make_char("B", 16'd4, 16'd4, 16'hFFFF, 16'h0000, 8'd0));
    send_char(make_char(8'd0, 16'd10, 16'd20, 16'hF800, 16'h07E0, 8'd2));
    send_char(make_char(8'd31, 16'd30, 16'd40, 16'h001F, 16'h0000, 8'd1));
    send_char(make_char(8'd32, 16'd30, 16'd40, 16'h001F, 16'h0000, 8'd1));
    send_char(make_char(8'd127, 16'd50, 16'd60, 16'hAAAA, 16'h5555, 8'd1));
    send_char(make_char(8'd128, 16'd50, 16'd60, 16'hAAAA, 16'h5555, 8'd1));
    send_char(make_char(8'd255, 16'd60, 16'd90, 16'h0F0F, 16'hF0F0, 8'd3));
    send_char(make_char("W", 16'd0, 16'd0, 16'h0000, 16'hFFFF, 8'd255));
    send_char(make_char("#", 16'hFFFE, 16'hFFFC, 16'h1111, 16'h2222, 8'd1));
    send_char(make_char("M", 16'd125, 16'd155, 16'h3333, 16'h4444, 8'd2));
    send_char(make_char("H", 16'd128, 16'd0, 16'h3333, 16'h4444, 8'd1));
    send_char(make_char("@", 16'hFFFF, 16'hFFFF, 16'h7777, 16'h8888, 8'd255));
    send_char(make_char("~", 16'd20, 16'd20, 16'hFFFF, 16'hFFFF, 8'd4));
    send_char(make_char("|", 16'd100, 16'd0, 16'hFFFF, 16'h0001, 8'd8));
    wait_drained();
  endtask

  task automatic test_screen_extremes();
    set_screen(11'd1, 11'd1);
    send_char(make_char("A", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd1));
    send_char(make_char("A", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd255));
    set_screen(11'd1024, 11'd1024);
    send_char(make_char("H", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd255));
    send_char(make_char("k", 16'd1023, 16'd1023, 16'h1234, 16'h4321, 8'd1));
    set_screen(11'd2047, 11'd2047);
    send_char(make_char("Z", 16'd900, 16'd900, 16'hCAFE, 16'h0000, 8'd200));
    send_char(make_char("g", 16'd1020, 16'd0, 16'h00FF, 16'hFF00, 8'd1));
    set_screen(11'd0, 11'd0);
    send_char(make_char("A", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd1));
    set_screen(11'd0, 11'd1024);
    send_char(make_char("Q", 16'd0, 16'd0, 16'hFFFF, 16'h0000, 8'd2));
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_screen(gcr_pkg::SCREEN_WIDTH_RESET, gcr_pkg::SCREEN_HEIGHT_RESET);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 10; i++) begin
      send_char(make_char(8'($urandom_range(33, 126)), 16'($urandom_range(0, 120)),
                          16'($urandom_range(0, 150)), 16'($urandom), 16'($urandom),
                          8'($urandom_range(1, 2))));
    end
    wait_drained();
  endtask

  task automatic test_random_chars();
    logic [10:0] widths [6];
    logic [10:0] heights [6];
    widths = '{11'd128, 11'd1024, 11'd37, 11'd2047, 11'd1, 11'd300};
    heights = '{11'd160, 11'd1024, 11'd2047, 11'd64, 11'd90, 11'd1};
    for (int p = 0; p < 6; p++) begin
      set_screen(widths[p], heights[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 25; i++) begin
        send_char(random_char());
        if (i == 12) wait_drained();
      end
    end
    set_screen(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_char(random_char());
    wait_drained();
  endtask

  initial begin
    char_ch.valid = 1'b0;
    char_ch.char_code = '0;
    char_ch.origin_x = '0;
    char_ch.origin_y = '0;
    char_ch.fg_color = '0;
    char_ch.back_color = '0;
    char_ch.scale = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = gcr_pkg::CFG_SCREEN_WIDTH;
    cfg_ch.data = '0;
    rect_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_chars();
    test_screen_extremes();
    test_output_backpressure();
    test_random_chars();
    $display("Checked %0d rectangles from %0d characters across %0d screen settings,",
             rects_seen, chars_sent, screens_used);
    $display("including substituted codes, wrap, clipping and output back-pressure.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rect_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rect_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        rect_ch.ready <= 1'b0;
      end else begin
        rect_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fill_rect_t want;
    if (!rst && rect_ch.valid && rect_ch.ready) begin
      rects_seen++;
      if (rects_due.size() == 0) begin
        $error("rectangle word with none expected: x %0d y %0d", rect_ch.rect_x,
               rect_ch.rect_y);
        failures++;
      end else begin
        want = rects_due.pop_front();
        if (rect_ch.rect_x !== want.rect_x) begin
          $error("rect_x: expected %0d, got %0d", want.rect_x, rect_ch.rect_x);
          failures++;
        end
        if (rect_ch.rect_y !== want.rect_y) begin
          $error("rect_y: expected %0d, got %0d", want.rect_y, rect_ch.rect_y);
          failures++;
        end
        if (rect_ch.rect_w !== want.rect_w) begin
          $error("rect_w: expected %0d, got %0d", want.rect_w, rect_ch.rect_w);
          failures++;
        end
        if (rect_ch.rect_h !== want.rect_h) begin
          $error("rect_h: expected %0d, got %0d", want.rect_h, rect_ch.rect_h);
          failures++;
        end
        if (rect_ch.rect_color !== want.rect_color) begin
          $error("rect_color: expected %h, got %h", want.rect_color, rect_ch.rect_color);
          failures++;
        end
        if (rect_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rect_ch.last);
          failures++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d rectangles outstanding.", rects_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
